// ===== hdl/mars_pkg.sv =====
// ----------------------------------------------------------------------------
// mars_pkg
// shared types, codes and constants for the modrm address, register and
// stack unit
// ----------------------------------------------------------------------------
package mars_pkg;

  // default stack size in bytes
  localparam int StackBytesDef = 1024;

  // operation codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_EA    = 3'd2;
  localparam logic [2:0] OP_PUSH  = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;

  // register codes
  localparam logic [2:0] REG_BX = 3'd3;
  localparam logic [2:0] REG_SP = 3'd4;
  localparam logic [2:0] REG_BP = 3'd5;
  localparam logic [2:0] REG_SI = 3'd6;
  localparam logic [2:0] REG_DI = 3'd7;

  // mod field codes
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // r_m code that means a direct address under mod 0
  localparam logic [2:0] RM_DIRECT = 3'b110;

  localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;
  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  register_index;
    logic        wide;
    logic [15:0] value;
    logic [1:0]  mode;
    logic [2:0]  rm;
    logic [7:0]  disp_low;
    logic [7:0]  disp_high;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] address;
    logic        is_register;
    logic [1:0]  disp_bytes;
    logic        stack_fault;
  } result_t;

  // datapath actions, one per cycle
  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_REG,
    CMD_RD_SP,
    CMD_RD_BASE,
    CMD_RD_INDEX,
    CMD_FIN_READ,
    CMD_FIN_WRITE,
    CMD_FIN_EA_FIXED,
    CMD_FIN_EA_SUM,
    CMD_PUSH_LO,
    CMD_PUSH_HI,
    CMD_POP_RD_LO,
    CMD_POP_LO,
    CMD_POP_HI,
    CMD_FIN_SP_WB,
    CMD_FIN_FAULT,
    CMD_FIN_NULL
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       wide;
    logic       ea_fixed;
    logic       push_fault;
    logic       pop_fault;
    logic       clr_last;
  } sts_t;

endpackage

// ===== hdl/mars_dp.sv =====
// ----------------------------------------------------------------------------
// mars_dp
// datapath: request register, register file, stack memory, address adder
// and result register
// ----------------------------------------------------------------------------
module mars_dp #(
  parameter int STACK_BYTES = mars_pkg::StackBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mars_pkg::item_t   item_i,
  input  mars_pkg::ctl_t    ctl_i,
  output mars_pkg::sts_t    sts_o,
  output mars_pkg::result_t result_o
);
  import mars_pkg::*;

  localparam int AW = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1;
  localparam logic [16:0] STACK_TOP = 17'(STACK_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(STACK_BYTES - 1);

  item_t         req_q;
  logic [15:0]   rf_q [8];
  logic [15:0]   rf_rdata_q;
  logic [15:0]   acc_q;
  logic [7:0]    mem [STACK_BYTES];
  logic [7:0]    mem_rdata_q;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [15:0]   sp_new_q, sp_new_d;
  logic [7:0]    pop_lo_q, pop_hi_q;
  logic [AW-1:0] clr_cnt_q;
  result_t       res_q, res_d;

  logic [2:0]    reg_sel, base_sel, idx_sel, rf_raddr, rf_waddr;
  logic          rf_re, rf_we;
  logic [15:0]   rf_wdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;
  logic [15:0]   sp, sp_push, sp_pop, disp, idx_term, ea_sum, merged;
  logic [15:0]   byte_rd;
  logic [16:0]   sp_ext;

  // register selection
  assign reg_sel = req_q.wide ? req_q.register_index : {1'b0, req_q.register_index[1:0]};
  assign idx_sel = req_q.rm[0] ? REG_DI : REG_SI;

  always_comb begin
    unique case (req_q.rm) inside
      3'd0, 3'd1, 3'd7: base_sel = REG_BX;
      3'd2, 3'd3, 3'd6: base_sel = REG_BP;
      3'd4:             base_sel = REG_SI;
      default:          base_sel = REG_DI;
    endcase
  end

  // stack pointer arithmetic, sp comes from the register file read
  assign sp      = rf_rdata_q;
  assign sp_ext  = {1'b0, sp};
  assign sp_push = sp - 16'd1 - {15'd0, req_q.wide};
  assign sp_pop  = sp + 16'd1 + {15'd0, req_q.wide};

  // address adder
  always_comb begin
    case (req_q.mode)
      MOD_DISP8:  disp = {{8{req_q.disp_low[7]}}, req_q.disp_low};
      MOD_DISP16: disp = {req_q.disp_high, req_q.disp_low};
      default:    disp = '0;
    endcase
  end
  assign idx_term = req_q.rm[2] ? 16'd0 : rf_rdata_q;
  assign ea_sum   = acc_q + idx_term + disp;

  // byte lanes
  assign byte_rd = req_q.wide ? rf_rdata_q :
                   req_q.register_index[2] ? {8'd0, rf_rdata_q[15:8]} :
                                             {8'd0, rf_rdata_q[7:0]};
  assign merged  = req_q.wide ? req_q.value :
                   req_q.register_index[2] ?
                     ((rf_rdata_q & LOW_BYTE_MASK) | {req_q.value[7:0], 8'd0}) :
                     ((rf_rdata_q & HIGH_BYTE_MASK) | {8'd0, req_q.value[7:0]});

  // port control
  always_comb begin
    rf_re     = 1'b0;
    rf_raddr  = reg_sel;
    rf_we     = 1'b0;
    rf_waddr  = reg_sel;
    rf_wdata  = merged;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = sp[AW-1:0];
    ptr_d     = ptr_q;
    sp_new_d  = sp_new_q;
    case (ctl_i.cmd)
      CMD_RD_REG: rf_re = 1'b1;
      CMD_RD_SP: begin
        rf_re    = 1'b1;
        rf_raddr = REG_SP;
      end
      CMD_RD_BASE: begin
        rf_re    = 1'b1;
        rf_raddr = base_sel;
      end
      CMD_RD_INDEX: begin
        rf_re    = 1'b1;
        rf_raddr = idx_sel;
      end
      CMD_FIN_WRITE: rf_we = 1'b1;
      CMD_CLEAR: mem_we = 1'b1;
      CMD_PUSH_LO: begin
        mem_we    = 1'b1;
        mem_waddr = sp_push[AW-1:0];
        mem_wdata = req_q.value[7:0];
        ptr_d     = sp_push[AW-1:0];
        sp_new_d  = sp_push;
      end
      CMD_PUSH_HI: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q + AW'(1);
        mem_wdata = req_q.value[15:8];
      end
      CMD_POP_RD_LO: begin
        mem_re   = 1'b1;
        ptr_d    = sp[AW-1:0];
        sp_new_d = sp_pop;
      end
      CMD_POP_LO: begin
        mem_re    = req_q.wide;
        mem_raddr = ptr_q + AW'(1);
      end
      CMD_FIN_SP_WB: begin
        rf_we    = 1'b1;
        rf_waddr = REG_SP;
        rf_wdata = sp_new_q;
      end
      default: ;
    endcase
  end

  // result forming
  always_comb begin
    res_d = '0;
    case (ctl_i.cmd)
      CMD_FIN_READ: res_d.read_data = byte_rd;
      CMD_FIN_EA_FIXED: begin
        if (req_q.mode == MOD_REG) begin
          res_d.is_register = 1'b1;
        end else begin
          res_d.address    = {req_q.disp_high, req_q.disp_low};
          res_d.disp_bytes = 2'd2;
        end
      end
      CMD_FIN_EA_SUM: begin
        res_d.address = ea_sum;
        case (req_q.mode)
          MOD_DISP8:  res_d.disp_bytes = 2'd1;
          MOD_DISP16: res_d.disp_bytes = 2'd2;
          default:    res_d.disp_bytes = 2'd0;
        endcase
      end
      CMD_FIN_SP_WB: begin
        if (req_q.operation == OP_POP) begin
          res_d.read_data = {pop_hi_q, pop_lo_q};
        end
      end
      CMD_FIN_FAULT: res_d.stack_fault = 1'b1;
      default: ;
    endcase
  end

  // register file, reset to zero with sp at the top of the stack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        rf_q[i] <= (3'(i) == REG_SP) ? 16'(STACK_BYTES) : 16'd0;
      end
    end else if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_re) begin
      rf_rdata_q <= rf_q[rf_raddr];
    end
  end

  // stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.cmd == CMD_CLEAR) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == CMD_LOAD) begin
      req_q <= item_i;
    end
    if (ctl_i.cmd == CMD_RD_INDEX) begin
      acc_q <= rf_rdata_q;
    end
    if (ctl_i.cmd == CMD_POP_LO) begin
      pop_lo_q <= mem_rdata_q;
      pop_hi_q <= '0;
    end
    if (ctl_i.cmd == CMD_POP_HI) begin
      pop_hi_q <= mem_rdata_q;
    end
    if (ctl_i.finish) begin
      res_q <= res_d;
    end
    ptr_q    <= ptr_d;
    sp_new_q <= sp_new_d;
  end

  assign sts_o.op         = req_q.operation;
  assign sts_o.wide       = req_q.wide;
  assign sts_o.ea_fixed   = (req_q.mode == MOD_REG) ||
                            (req_q.mode == MOD_NODISP && req_q.rm == RM_DIRECT);
  assign sts_o.push_fault = (sp_ext < 17'd1 + {16'd0, req_q.wide}) || (sp_ext > STACK_TOP);
  assign sts_o.pop_fault  = (sp_ext + {16'd0, req_q.wide}) >= STACK_TOP;
  assign sts_o.clr_last   = (clr_cnt_q == CLR_LAST);
  assign result_o         = res_q;

  // every stack write stays inside the stack
  a_mem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < STACK_BYTES))
    else $error("stack write outside the stack");

  // a faulted access returns no data
  a_fault_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish |=> (!res_q.stack_fault || res_q.read_data == 16'd0))
    else $error("stack fault with nonzero data");

endmodule

// ===== hdl/mars_ctrl.sv =====
// ----------------------------------------------------------------------------
// mars_ctrl
// controller: sequences the datapath through the steps of each operation
// ----------------------------------------------------------------------------
module mars_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  input  mars_pkg::sts_t sts_i,
  output mars_pkg::ctl_t ctl_o
);
  import mars_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_R_DONE,
    S_W_DONE,
    S_EA_IDX,
    S_EA_SUM,
    S_PUSH_CHK,
    S_PUSH_HI,
    S_POP_CHK,
    S_POP_LO,
    S_POP_HI,
    S_SP_WB
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q;
  ctl_t   ctl;

  always_comb begin
    state_d    = state_q;
    ctl.cmd    = CMD_IDLE;
    ctl.finish = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !busy_q) begin
          ctl.cmd = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_READ: begin
            ctl.cmd = CMD_RD_REG;
            state_d = S_R_DONE;
          end
          OP_WRITE: begin
            ctl.cmd = CMD_RD_REG;
            state_d = S_W_DONE;
          end
          OP_EA: begin
            if (sts_i.ea_fixed) begin
              ctl.cmd    = CMD_FIN_EA_FIXED;
              ctl.finish = 1'b1;
              state_d    = S_IDLE;
            end else begin
              ctl.cmd = CMD_RD_BASE;
              state_d = S_EA_IDX;
            end
          end
          OP_PUSH: begin
            ctl.cmd = CMD_RD_SP;
            state_d = S_PUSH_CHK;
          end
          OP_POP: begin
            ctl.cmd = CMD_RD_SP;
            state_d = S_POP_CHK;
          end
          default: begin
            ctl.cmd    = CMD_FIN_NULL;
            ctl.finish = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_R_DONE: begin
        ctl.cmd    = CMD_FIN_READ;
        ctl.finish = 1'b1;
        state_d    = S_IDLE;
      end
      S_W_DONE: begin
        ctl.cmd    = CMD_FIN_WRITE;
        ctl.finish = 1'b1;
        state_d    = S_IDLE;
      end
      S_EA_IDX: begin
        ctl.cmd = CMD_RD_INDEX;
        state_d = S_EA_SUM;
      end
      S_EA_SUM: begin
        ctl.cmd    = CMD_FIN_EA_SUM;
        ctl.finish = 1'b1;
        state_d    = S_IDLE;
      end
      S_PUSH_CHK: begin
        if (sts_i.push_fault) begin
          ctl.cmd    = CMD_FIN_FAULT;
          ctl.finish = 1'b1;
          state_d    = S_IDLE;
        end else begin
          ctl.cmd = CMD_PUSH_LO;
          state_d = sts_i.wide ? S_PUSH_HI : S_SP_WB;
        end
      end
      S_PUSH_HI: begin
        ctl.cmd = CMD_PUSH_HI;
        state_d = S_SP_WB;
      end
      S_POP_CHK: begin
        if (sts_i.pop_fault) begin
          ctl.cmd    = CMD_FIN_FAULT;
          ctl.finish = 1'b1;
          state_d    = S_IDLE;
        end else begin
          ctl.cmd = CMD_POP_RD_LO;
          state_d = S_POP_LO;
        end
      end
      S_POP_LO: begin
        ctl.cmd = CMD_POP_LO;
        state_d = sts_i.wide ? S_POP_HI : S_SP_WB;
      end
      S_POP_HI: begin
        ctl.cmd = CMD_POP_HI;
        state_d = S_SP_WB;
      end
      S_SP_WB: begin
        ctl.cmd    = CMD_FIN_SP_WB;
        ctl.finish = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= ctl.finish;
    end
  end

  assign ctl_o  = ctl;
  assign busy   = busy_q;
  assign done_o = done_q;

  // every strobe comes from a finishing step in the cycle before
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(ctl.finish))
    else $error("result strobe without a finishing step");

  // an accepted start always makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q) |=> busy_q)
    else $error("start accepted but block not busy");

  // no request is taken during the stack clear sweep
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (busy_q && !done_q))
    else $error("block idle or strobing during clear sweep");

endmodule

// ===== hdl/modrm_address_register_stack_unit.sv =====
// ----------------------------------------------------------------------------
// modrm_address_register_stack_unit
// eight 16-bit registers, mod/r_m effective address unit and byte stack
// ----------------------------------------------------------------------------
// usage
//   request channel: item_i is taken at a rising edge with start high and
//   busy low. one transfer carries operation, register code, width, value,
//   mod, r_m and both displacement bytes.
//   result channel: done_o is high for exactly one cycle per request and
//   marks result_o; the receiver cannot stall, so it must take the transfer
//   in that cycle. results leave in request order.
//   busy drops in the cycle that done_o rises, so a new request can be taken
//   then, not before. the single-port register file read and the byte-wide
//   stack memory port allow one register or one stack byte per cycle.
//   reset: registers clear to zero with sp at the stack top, then a clear
//   sweep writes zero to every stack byte, one byte a cycle; busy stays high
//   until it ends.
// ----------------------------------------------------------------------------
module modrm_address_register_stack_unit #(
  parameter int STACK_BYTES = mars_pkg::StackBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mars_pkg::item_t   item_i,
  output logic              done_o,
  output mars_pkg::result_t result_o
);
  import mars_pkg::*;

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  // sequencer: clear sweep, decode and per-operation steps
  mars_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // datapath: register file, stack memory, address adder, result register
  mars_dp #(
    .STACK_BYTES (STACK_BYTES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

// ===== bench/tb_modrm_address_register_stack_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modrm_address_register_stack_unit
// self-checking bench for the register file, mod/r_m address unit and stack
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a falling-edge driver; a rising-edge
// monitor mirrors every accepted request in a local copy of the registers
// and stack bytes, queues the result it should produce and compares each
// done_o transfer field by field. a directed opener hits byte lanes, every
// addressing form and both stack limits, then random phases vary the
// sender's idle rate.
// ----------------------------------------------------------------------------
module tb_modrm_address_register_stack_unit;
  import mars_pkg::*;

  localparam int STACK_BYTES = StackBytesDef;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 10;

  // codes the package leaves unnamed
  localparam logic [2:0] REG_AX         = 3'd0;
  localparam logic [2:0] REG_AH         = 3'd4;
  localparam logic [2:0] RM_BX_SI       = 3'd0;
  localparam logic [2:0] RM_BP_SI       = 3'd2;
  localparam logic [2:0] RM_BP_DI       = 3'd3;
  localparam logic [2:0] RM_DI          = 3'd5;
  localparam logic [2:0] RM_BX          = 3'd7;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  modrm_address_register_stack_unit #(
    .STACK_BYTES(STACK_BYTES)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // mirror of the block state
  // ---------------------------------------------------------------------------
  logic [15:0] gpr [8];
  logic [7:0]  stack_mem [STACK_BYTES];

  item_t       requests_pending [$];
  result_t     results_due [$];
  int unsigned idle_pct;
  int unsigned n_issued;
  int unsigned n_taken;
  int unsigned n_checked;
  int unsigned n_faults;
  int unsigned n_mismatch;
  int unsigned cycle_count;
  int unsigned taken_by_op [8];
  result_t     want;

  function automatic void clear_mirror();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    gpr[REG_SP] = 16'(STACK_BYTES);
  endfunction

  // base plus index sum chosen by r_m
  function automatic logic [15:0] ea_base(logic [2:0] rm);
    case (rm)
      3'd0:    return gpr[REG_BX] + gpr[REG_SI];
      3'd1:    return gpr[REG_BX] + gpr[REG_DI];
      3'd2:    return gpr[REG_BP] + gpr[REG_SI];
      3'd3:    return gpr[REG_BP] + gpr[REG_DI];
      3'd4:    return gpr[REG_SI];
      3'd5:    return gpr[REG_DI];
      3'd6:    return gpr[REG_BP];
      default: return gpr[REG_BX];
    endcase
  endfunction

  // applies one request to the mirror and returns the result it must give
  function automatic result_t emulate_access(item_t it);
    result_t     r;
    logic [15:0] sp;
    logic [1:0]  lane;
    int          nsp;
    r    = '0;
    sp   = gpr[REG_SP];
    lane = it.register_index[1:0];
    case (it.operation)
      OP_READ: begin
        if (it.wide) begin
          r.read_data = gpr[it.register_index];
        end else if (!it.register_index[2]) begin
          r.read_data = {8'h00, gpr[lane][7:0]};
        end else begin
          r.read_data = {8'h00, gpr[lane][15:8]};
        end
      end
      OP_WRITE: begin
        if (it.wide) begin
          gpr[it.register_index] = it.value;
        end else if (!it.register_index[2]) begin
          gpr[lane][7:0] = it.value[7:0];
        end else begin
          gpr[lane][15:8] = it.value[7:0];
        end
      end
      OP_EA: begin
        if (it.mode == MOD_REG) begin
          r.is_register = 1'b1;
        end else if (it.mode == MOD_NODISP && it.rm == RM_DIRECT) begin
          r.address    = {it.disp_high, it.disp_low};
          r.disp_bytes = 2'd2;
        end else if (it.mode == MOD_NODISP) begin
          r.address = ea_base(it.rm);
        end else if (it.mode == MOD_DISP8) begin
          // one displacement byte, sign-extended
          r.address    = ea_base(it.rm) + {{8{it.disp_low[7]}}, it.disp_low};
          r.disp_bytes = 2'd1;
        end else begin
          r.address    = ea_base(it.rm) + {it.disp_high, it.disp_low};
          r.disp_bytes = 2'd2;
        end
      end
      OP_PUSH: begin
        if (int'(sp) < 1 + int'(it.wide) || int'(sp) > STACK_BYTES) begin
          r.stack_fault = 1'b1;
        end else begin
          nsp = int'(sp) - 1 - int'(it.wide);
          stack_mem[nsp] = it.value[7:0];
          if (it.wide) stack_mem[nsp + 1] = it.value[15:8];
          gpr[REG_SP] = 16'(nsp);
        end
      end
      OP_POP: begin
        if (int'(sp) + int'(it.wide) >= STACK_BYTES) begin
          r.stack_fault = 1'b1;
        end else begin
          r.read_data = {8'h00, stack_mem[sp]};
          if (it.wide) r.read_data[15:8] = stack_mem[sp + 16'd1];
          gpr[REG_SP] = sp + 16'd1 + 16'(it.wide);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_request(logic [2:0] op, logic [2:0] idx, logic wide,
                                         logic [15:0] value, logic [1:0] mode,
                                         logic [2:0] rm, logic [7:0] dl, logic [7:0] dh);
    item_t it;
    it.operation      = op;
    it.register_index = idx;
    it.wide           = wide;
    it.value          = value;
    it.mode           = mode;
    it.rm             = rm;
    it.disp_low       = dl;
    it.disp_high      = dh;
    return it;
  endfunction

  // random request; all fields random, operation weighted, sp writes steered
  // toward the stack limits so faults on both ends keep turning up
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    it.operation      = OP_READ;
    it.register_index = 3'($urandom_range(7));
    it.wide           = 1'($urandom_range(1));
    it.value          = 16'($urandom);
    it.mode           = 2'($urandom_range(3));
    it.rm             = 3'($urandom_range(7));
    it.disp_low       = 8'($urandom);
    it.disp_high      = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 14) begin
      it.operation = OP_READ;
    end else if (pick < 34) begin
      it.operation = OP_WRITE;
      if (pick < 20) begin
        it.register_index = REG_SP;
        it.wide           = 1'b1;
      end
      if (it.register_index == REG_SP && it.wide && $urandom_range(3) != 0) begin
        case ($urandom_range(3))
          0:       it.value = 16'($urandom_range(3));
          1:       it.value = 16'(STACK_BYTES - 2 + $urandom_range(3));
          default: it.value = 16'($urandom_range(STACK_BYTES));
        endcase
      end
    end else if (pick < 52) begin
      it.operation = OP_EA;
    end else if (pick < 74) begin
      it.operation = OP_PUSH;
    end else if (pick < 96) begin
      it.operation = OP_POP;
    end else begin
      it.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: moves on once the current request transferred, or while idle
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!start || n_taken == n_issued)) begin
      if (requests_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        item_i   <= requests_pending.pop_front();
        start    <= 1'b1;
        n_issued <= n_issued + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check the result transfer, then predict for an accepted request
  // (a result never belongs to the request taken at the same edge)
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_mirror();
    end else begin
      if (done_o) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing outstanding: %p", result_o);
          n_mismatch++;
        end else begin
          want = results_due.pop_front();
          n_checked++;
          if (result_o.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, result_o.read_data);
            n_mismatch++;
          end
          if (result_o.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, result_o.address);
            n_mismatch++;
          end
          if (result_o.is_register !== want.is_register) begin
            $error("is_register: expected %b, got %b", want.is_register,
                   result_o.is_register);
            n_mismatch++;
          end
          if (result_o.disp_bytes !== want.disp_bytes) begin
            $error("disp_bytes: expected %0d, got %0d", want.disp_bytes,
                   result_o.disp_bytes);
            n_mismatch++;
          end
          if (result_o.stack_fault !== want.stack_fault) begin
            $error("stack_fault: expected %b, got %b", want.stack_fault,
                   result_o.stack_fault);
            n_mismatch++;
          end
        end
      end
      if (start && !busy) begin
        results_due.push_back(emulate_access(item_i));
        if (results_due[$].stack_fault) n_faults++;
        taken_by_op[item_i.operation]++;
        n_taken <= n_taken + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int unsigned phase_items [4] = '{400, 350, 400, 400};
  int unsigned phase_idle  [4] = '{0, 82, 31, 0};

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    idle_pct    = 0;
    n_issued    = 0;
    n_taken     = 0;
    n_checked   = 0;
    n_faults    = 0;
    n_mismatch  = 0;
    cycle_count = 0;
    foreach (taken_by_op[i]) taken_by_op[i] = 0;

    // byte lanes: high byte code lands in ax, low byte stays
    requests_pending.push_back(make_request(OP_WRITE, REG_AX, 1'b1, 16'hFFFF, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_WRITE, REG_AH, 1'b0, 16'hA512, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_READ, REG_AH, 1'b0, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_READ, REG_AX, 1'b0, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_READ, REG_AX, 1'b1, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    // base and index registers at their extremes
    requests_pending.push_back(make_request(OP_WRITE, REG_BX, 1'b1, 16'h8000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_WRITE, REG_SI, 1'b1, 16'h7FFF, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_WRITE, REG_DI, 1'b1, 16'hFFFF, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_WRITE, REG_BP, 1'b1, 16'h0001, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    // direct address, no displacement, negative and positive disp8, wrapping
    // disp16, register operand
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_NODISP,
                                            RM_DIRECT, 8'h34, 8'h12));
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_NODISP,
                                            RM_BX_SI, 8'hFF, 8'hFF));
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_DISP8,
                                            RM_BX, 8'h80, 8'h00));
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_DISP8,
                                            RM_DI, 8'h7F, 8'hFF));
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_DISP16,
                                            RM_BP_DI, 8'hFF, 8'hFF));
    requests_pending.push_back(make_request(OP_EA, REG_AX, 1'b0, 16'h0000, MOD_REG,
                                            RM_BP_SI, 8'h12, 8'h34));
    // word and byte round trip through the stack
    requests_pending.push_back(make_request(OP_PUSH, REG_AX, 1'b1, 16'hABCD, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_PUSH, REG_AX, 1'b0, 16'hFF5A, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_POP, REG_AX, 1'b0, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_POP, REG_AX, 1'b1, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    // bottom of stack: word push faults, byte push fits
    requests_pending.push_back(make_request(OP_WRITE, REG_SP, 1'b1, 16'h0001, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_PUSH, REG_AX, 1'b1, 16'h1234, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_PUSH, REG_AX, 1'b0, 16'h00C3, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    // top of stack: word pop faults, byte pop fits, then sp out of range
    requests_pending.push_back(make_request(OP_WRITE, REG_SP, 1'b1, 16'(STACK_BYTES - 1),
                                            2'd0, 3'd0, 8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_POP, REG_AX, 1'b1, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_POP, REG_AX, 1'b0, 16'h0000, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_WRITE, REG_SP, 1'b1, 16'hFFFF, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    requests_pending.push_back(make_request(OP_PUSH, REG_AX, 1'b0, 16'h0077, 2'd0, 3'd0,
                                            8'h00, 8'h00));
    // spare operation codes do nothing
    requests_pending.push_back(make_request(OP_SPARE_FIRST, REG_SP, 1'b1, 16'hFFFF,
                                            MOD_REG, 3'd7, 8'hFF, 8'hFF));
    requests_pending.push_back(make_request(OP_SPARE_LAST, REG_AX, 1'b0, 16'h0000,
                                            MOD_NODISP, 3'd0, 8'h00, 8'h00));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // random phases, each with the sender idle rate given in phase_idle
    for (int p = 0; p < 4; p++) begin
      wait (requests_pending.size() == 0);
      idle_pct = phase_idle[p];
      for (int i = 0; i < int'(phase_items[p]); i++) requests_pending.push_back(random_item());
    end

    wait (requests_pending.size() == 0 && n_taken == n_issued && results_due.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d transfers: %0d reads, %0d writes, %0d addresses, %0d pushes, %0d pops",
             n_taken, taken_by_op[OP_READ], taken_by_op[OP_WRITE], taken_by_op[OP_EA],
             taken_by_op[OP_PUSH], taken_by_op[OP_POP]);
    $display("%0d stack faults, %0d results checked, %0d mismatches",
             n_faults, n_checked, n_mismatch);
    if (n_mismatch == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== modrm_address_register_stack_unit.f =====
hdl/mars_pkg.sv
hdl/mars_dp.sv
hdl/mars_ctrl.sv
hdl/modrm_address_register_stack_unit.sv
bench/tb_modrm_address_register_stack_unit.sv
